/* sv/bfgs_pkg.sv */
// ----------------------------------------------------------------------------
// bfgs_pkg
// Shared constants, command codes and state type of the header bit-field
// get/set block.
// ----------------------------------------------------------------------------
`default_nettype none

package bfgs_pkg;

  localparam int BUF_BYTES      = 256;
  localparam int MAX_FIELD_BITS = 64;

  localparam int BYTE_W    = 8;
  localparam int ADDR_W    = 8;
  localparam int CMD_W     = 2;
  localparam int OFF_W     = 11;
  localparam int LEN_W     = 7;
  localparam int FIELD_W   = 64;

  // Buffer organization: rows of 64 bits, byte 0 of a row in its top bits,
  // even rows in one bank and odd rows in the other.
  localparam int ROW_W      = 64;
  localparam int ROW_BYTES  = ROW_W / BYTE_W;
  localparam int ROW_OFF_W  = $clog2(ROW_W);
  localparam int ROWS       = BUF_BYTES / ROW_BYTES;
  localparam int ROW_IDX_W  = $clog2(ROWS);
  localparam int BANK_DEPTH = ROWS / 2;
  localparam int BANK_AW    = ROW_IDX_W - 1;
  localparam int WIN_W      = 2 * ROW_W;
  localparam int SH_W       = $clog2(WIN_W);
  localparam int BUF_BITS   = BUF_BYTES * BYTE_W;

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_WR_BYTE = 2'd0;
  localparam cmd_t CMD_RD_BYTE = 2'd1;
  localparam cmd_t CMD_EXTRACT = 2'd2;
  localparam cmd_t CMD_INSERT  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_t;

endpackage

`default_nettype wire

/* sv/bfgs_ram.sv */
// ----------------------------------------------------------------------------
// bfgs_ram
// One row bank of the header buffer: one write port, one read port with
// registered read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module bfgs_ram (
  input  wire                          clk,
  input  wire                          we,
  input  wire [bfgs_pkg::BANK_AW-1:0]  waddr,
  input  wire [bfgs_pkg::ROW_W-1:0]    wdata,
  input  wire [bfgs_pkg::BANK_AW-1:0]  raddr,
  output logic [bfgs_pkg::ROW_W-1:0]   rdata
);

  logic [bfgs_pkg::ROW_W-1:0] mem [bfgs_pkg::BANK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/bfgs_field.sv */
// ----------------------------------------------------------------------------
// bfgs_field
// Field alignment over a two-row window: extract a right-aligned field and
// merge a new field value into the window, leaving other bits intact.
// ----------------------------------------------------------------------------
`default_nettype none

module bfgs_field (
  input  wire  [bfgs_pkg::WIN_W-1:0]   win_i,
  input  wire  [bfgs_pkg::SH_W-1:0]    sh_i,
  input  wire  [bfgs_pkg::LEN_W-1:0]   len_i,
  input  wire  [bfgs_pkg::FIELD_W-1:0] val_i,
  output logic [bfgs_pkg::FIELD_W-1:0] field_o,
  output logic [bfgs_pkg::WIN_W-1:0]   mask_o,
  output logic [bfgs_pkg::WIN_W-1:0]   win_o
);

  logic [bfgs_pkg::FIELD_W-1:0] len_mask;
  logic [bfgs_pkg::WIN_W-1:0]   val_w;
  logic [bfgs_pkg::WIN_W-1:0]   shifted;

  // Build a mask of len_i ones at the bottom.
  always_comb begin
    if (32'(len_i) >= bfgs_pkg::FIELD_W) begin
      len_mask = '1;
    end else begin
      len_mask = (bfgs_pkg::FIELD_W'(1) << len_i) - bfgs_pkg::FIELD_W'(1);
    end
  end

  // Shift the field down to bit 0 and drop the bits around it.
  assign shifted = win_i >> sh_i;
  assign field_o = shifted[bfgs_pkg::FIELD_W-1:0] & len_mask;

  // Move the new value up to its place and merge.
  assign mask_o = bfgs_pkg::WIN_W'(len_mask) << sh_i;
  assign val_w  = bfgs_pkg::WIN_W'(val_i & len_mask) << sh_i;
  assign win_o  = (win_i & ~mask_o) | val_w;

endmodule

`default_nettype wire

/* sv/packet_bit_field_get_set.sv */
// ----------------------------------------------------------------------------
// packet_bit_field_get_set
// Sequencing: an accepted command runs through the read of the row banks
//   (READ) and the modify/write-back step (EXEC), which loads the result.
// Commands run one at a time: a new one is taken only after EXEC ends.
// Reset: clears the sequencer and the result valid; buffer contents stay
//   undefined until written (no clearing pass).
// ----------------------------------------------------------------------------
`default_nettype none

module packet_bit_field_get_set (
  input  wire                          clk,
  input  wire                          rst_n,
  // command word
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [bfgs_pkg::CMD_W-1:0]   in_cmd,
  input  wire  [bfgs_pkg::ADDR_W-1:0]  in_byte_addr,
  input  wire  [bfgs_pkg::BYTE_W-1:0]  in_byte_in,
  input  wire  [bfgs_pkg::OFF_W-1:0]   in_bit_offset,
  input  wire  [bfgs_pkg::LEN_W-1:0]   in_bit_length,
  input  wire  [bfgs_pkg::FIELD_W-1:0] in_field_in,
  // result word
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [bfgs_pkg::FIELD_W-1:0] out_field_out,
  output logic [bfgs_pkg::BYTE_W-1:0]  out_byte_out,
  output logic                         out_range_error
);

  // The buffer is held as 64-bit rows split across an even and an odd bank.
  // Any field of up to 64 bits lies within two consecutive rows, so one read
  // of both banks fetches the whole window. Byte commands are handled as
  // 8-bit fields at offset 8*addr through the same path.

  bfgs_pkg::state_t state_r, state_nxt;

  bfgs_pkg::cmd_t                 cmd_r;
  logic [bfgs_pkg::OFF_W-1:0]     off_r;
  logic [bfgs_pkg::LEN_W-1:0]     len_r;
  logic [bfgs_pkg::FIELD_W-1:0]   val_r;
  logic                           err_r;

  bfgs_pkg::cmd_t                 cmd_nxt;
  logic [bfgs_pkg::OFF_W-1:0]     off_nxt;
  logic [bfgs_pkg::LEN_W-1:0]     len_nxt;
  logic [bfgs_pkg::FIELD_W-1:0]   val_nxt;
  logic                           err_nxt;

  logic                           out_valid_r;
  logic [bfgs_pkg::FIELD_W-1:0]   out_field_r;
  logic [bfgs_pkg::BYTE_W-1:0]    out_byte_r;
  logic                           out_err_r;

  logic                           in_accept;
  logic                           exec_go;
  logic                           is_write;

  logic [bfgs_pkg::ROW_IDX_W-1:0] row0;
  logic [bfgs_pkg::ROW_IDX_W-1:0] row_even;
  logic [bfgs_pkg::ROW_OFF_W-1:0] row_off;
  logic [bfgs_pkg::SH_W:0]        sh_full;
  logic [bfgs_pkg::SH_W-1:0]      sh;

  logic [bfgs_pkg::BANK_AW-1:0]   even_addr;
  logic [bfgs_pkg::BANK_AW-1:0]   odd_addr;
  logic [bfgs_pkg::ROW_W-1:0]     even_rd, odd_rd;
  logic [bfgs_pkg::ROW_W-1:0]     even_wd, odd_wd;
  logic                           even_we, odd_we;

  logic [bfgs_pkg::WIN_W-1:0]     win;
  logic [bfgs_pkg::WIN_W-1:0]     win_new;
  logic [bfgs_pkg::WIN_W-1:0]     win_mask;
  logic [bfgs_pkg::FIELD_W-1:0]   field_val;
  logic                           hi_touch, lo_touch;

  assign in_accept = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Command decode at accept: turn byte commands into 8-bit fields and run
  // the range check up front.
  // --------------------------------------------------------------------------
  always_comb begin
    cmd_nxt = bfgs_pkg::cmd_t'(in_cmd);
    if (!in_cmd[1]) begin
      off_nxt = bfgs_pkg::OFF_W'({in_byte_addr, 3'b000});
      len_nxt = bfgs_pkg::LEN_W'(bfgs_pkg::BYTE_W);
      val_nxt = bfgs_pkg::FIELD_W'(in_byte_in);
      err_nxt = 32'(in_byte_addr) >= bfgs_pkg::BUF_BYTES;
    end else begin
      off_nxt = in_bit_offset;
      len_nxt = in_bit_length;
      val_nxt = in_field_in;
      err_nxt = (in_bit_length == '0)
             || (32'(in_bit_length) > bfgs_pkg::MAX_FIELD_BITS)
             || (32'(in_bit_offset) + 32'(in_bit_length) > bfgs_pkg::BUF_BITS);
    end
  end

  // --------------------------------------------------------------------------
  // Window addressing: first row of the field and the row after it.
  // --------------------------------------------------------------------------
  assign row0     = off_r[bfgs_pkg::OFF_W-1:bfgs_pkg::ROW_OFF_W];
  assign row_off  = off_r[bfgs_pkg::ROW_OFF_W-1:0];
  // Even row of the pair; wraps past the last row, which is never touched.
  assign row_even = row0 + bfgs_pkg::ROW_IDX_W'(row0[0]);
  assign even_addr = row_even[bfgs_pkg::ROW_IDX_W-1:1];
  assign odd_addr  = row0[bfgs_pkg::ROW_IDX_W-1:1];

  // Right shift that brings the last field bit to bit 0 of the window.
  assign sh_full = (bfgs_pkg::SH_W+1)'(bfgs_pkg::WIN_W)
                 - (bfgs_pkg::SH_W+1)'(row_off)
                 - (bfgs_pkg::SH_W+1)'(len_r);
  assign sh      = sh_full[bfgs_pkg::SH_W-1:0];

  // First row goes on top of the window.
  assign win = row0[0] ? {odd_rd, even_rd} : {even_rd, odd_rd};

  bfgs_ram u_bank_even (
    .clk   (clk),
    .we    (even_we),
    .waddr (even_addr),
    .wdata (even_wd),
    .raddr (even_addr),
    .rdata (even_rd)
  );

  bfgs_ram u_bank_odd (
    .clk   (clk),
    .we    (odd_we),
    .waddr (odd_addr),
    .wdata (odd_wd),
    .raddr (odd_addr),
    .rdata (odd_rd)
  );

  bfgs_field u_field (
    .win_i   (win),
    .sh_i    (sh),
    .len_i   (len_r),
    .val_i   (val_r),
    .field_o (field_val),
    .mask_o  (win_mask),
    .win_o   (win_new)
  );

  // Split the merged window back onto the banks; write only rows the field
  // actually covers.
  assign hi_touch = |win_mask[bfgs_pkg::WIN_W-1:bfgs_pkg::ROW_W];
  assign lo_touch = |win_mask[bfgs_pkg::ROW_W-1:0];
  assign even_wd  = row0[0] ? win_new[bfgs_pkg::ROW_W-1:0]
                            : win_new[bfgs_pkg::WIN_W-1:bfgs_pkg::ROW_W];
  assign odd_wd   = row0[0] ? win_new[bfgs_pkg::WIN_W-1:bfgs_pkg::ROW_W]
                            : win_new[bfgs_pkg::ROW_W-1:0];

  assign is_write = (cmd_r == bfgs_pkg::CMD_WR_BYTE) || (cmd_r == bfgs_pkg::CMD_INSERT);

  // --------------------------------------------------------------------------
  // Sequencer: next state.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfgs_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = bfgs_pkg::ST_READ;
        end
      end
      bfgs_pkg::ST_READ: begin
        state_nxt = bfgs_pkg::ST_EXEC;
      end
      bfgs_pkg::ST_EXEC: begin
        if (exec_go) begin
          state_nxt = bfgs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bfgs_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs. Hold in EXEC while the result register is full and
  // stalled; write back only on the cycle the result is loaded.
  // --------------------------------------------------------------------------
  always_comb begin
    in_stall = 1'b1;
    exec_go  = 1'b0;
    even_we  = 1'b0;
    odd_we   = 1'b0;
    unique case (state_r)
      bfgs_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      bfgs_pkg::ST_READ: begin
        in_stall = 1'b1;
      end
      bfgs_pkg::ST_EXEC: begin
        exec_go = !out_valid_r || !out_stall;
        if (exec_go && is_write && !err_r) begin
          even_we = row0[0] ? lo_touch : hi_touch;
          odd_we  = row0[0] ? hi_touch : lo_touch;
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfgs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Command word: capture on accept, hold while the command runs.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r <= cmd_nxt;
      off_r <= off_nxt;
      len_r <= len_nxt;
      val_r <= val_nxt;
      err_r <= err_nxt;
    end
  end

  // Result register: load in EXEC, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_err_r   <= err_r;
      out_field_r <= (cmd_r == bfgs_pkg::CMD_EXTRACT && !err_r) ? field_val : '0;
      out_byte_r  <= (cmd_r == bfgs_pkg::CMD_RD_BYTE && !err_r)
                   ? field_val[bfgs_pkg::BYTE_W-1:0] : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_field_out   = out_field_r;
  assign out_byte_out    = out_byte_r;
  assign out_range_error = out_err_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_write_only_good_store: assert property (@(posedge clk) disable iff (!rst_n)
    (even_we || odd_we) |-> (state_r == bfgs_pkg::ST_EXEC && is_write && !err_r))
    else $error("bank write outside a valid store command");

  a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == bfgs_pkg::ST_READ))
    else $error("accepted command did not start a bank read");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == bfgs_pkg::ST_EXEC))
    else $error("result appeared without an execute cycle");

  a_error_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_field_r == '0 && out_byte_r == '0))
    else $error("refused command returned nonzero data");

endmodule

`default_nettype wire

/* test/tb_packet_bit_field_get_set.sv */
// ----------------------------------------------------------------------------
// tb_packet_bit_field_get_set
// Self-checking bench for the header bit-field get/set block. A scoreboard
// keeps its own copy of the header buffer. It works out the result of every
// accepted command word and compares each result word with the oldest one
// still outstanding. A directed opening hits the field extremes and the
// refusal cases. A fill of every byte follows, then random traffic that
// crowds field accesses at both ends of the buffer. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_packet_bit_field_get_set;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 8;
  localparam int RANDOM_WORDS = 1520;  // after the fill, about 1800 words in total
  localparam int CALM_FIRST   = 700;   // window of random words with no idling
  localparam int CALM_LAST    = 1000;
  localparam int IDLE_PCT     = 34;
  localparam int DRAIN_CYCLES = 10;
  localparam int QUIET_LIMIT  = 2000;

  // Expected contents of one result word.
  typedef struct packed {
    logic [bfgs_pkg::FIELD_W-1:0] field_val;
    logic [bfgs_pkg::BYTE_W-1:0]  byte_val;
    logic                         range_err;
  } result_word_t;

  // Header image plus the queue of results still owed by the block.
  class header_scoreboard;
    logic [bfgs_pkg::BYTE_W-1:0] hdr [bfgs_pkg::BUF_BYTES];
    result_word_t                owed_q [$];
    int unsigned                 mismatches;
    int unsigned                 refused;
    int unsigned                 cmd_seen [4];

    function new();
      foreach (hdr[k]) hdr[k] = '0;
      foreach (cmd_seen[k]) cmd_seen[k] = 0;
      mismatches = 0;
      refused    = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Bit n of the header is bit (7 - n mod 8) of byte n/8.
    function logic hdr_bit(int pos);
      return hdr[pos >> 3][7 - (pos & 7)];
    endfunction

    function void note_word(bfgs_pkg::cmd_t c,
                            logic [bfgs_pkg::ADDR_W-1:0] a,
                            logic [bfgs_pkg::BYTE_W-1:0] b,
                            logic [bfgs_pkg::OFF_W-1:0] off,
                            logic [bfgs_pkg::LEN_W-1:0] len,
                            logic [bfgs_pkg::FIELD_W-1:0] fin);
      result_word_t r;
      int first;
      int nbits;
      int pos;
      r     = '0;
      first = int'(off);
      nbits = int'(len);
      cmd_seen[c]++;
      case (c)
        bfgs_pkg::CMD_WR_BYTE: begin
          if (int'(a) < bfgs_pkg::BUF_BYTES) hdr[a] = b;
          else r.range_err = 1'b1;
        end
        bfgs_pkg::CMD_RD_BYTE: begin
          if (int'(a) < bfgs_pkg::BUF_BYTES) r.byte_val = hdr[a];
          else r.range_err = 1'b1;
        end
        default: begin
          if (nbits == 0 || nbits > bfgs_pkg::MAX_FIELD_BITS
              || first + nbits > bfgs_pkg::BUF_BITS) begin
            r.range_err = 1'b1;
          end else if (c == bfgs_pkg::CMD_EXTRACT) begin
            for (int i = 0; i < nbits; i++)
              r.field_val = {r.field_val[bfgs_pkg::FIELD_W-2:0], hdr_bit(first + i)};
          end else begin
            // last field bit lands on bit 0 of the value; higher value bits drop
            for (int i = 0; i < nbits; i++) begin
              pos = first + i;
              hdr[pos >> 3][7 - (pos & 7)] = fin[nbits - 1 - i];
            end
          end
        end
      endcase
      if (r.range_err) refused++;
      owed_q.push_back(r);
    endfunction

    function void check_word(logic [bfgs_pkg::FIELD_W-1:0] f,
                             logic [bfgs_pkg::BYTE_W-1:0] b, logic e);
      result_word_t x;
      if (owed_q.size() == 0) begin
        $error("result word arrived with nothing outstanding");
        mismatches++;
        return;
      end
      x = owed_q.pop_front();
      if (f !== x.field_val) begin
        $error("field_out: expected %h, got %h", x.field_val, f);
        mismatches++;
      end
      if (b !== x.byte_val) begin
        $error("byte_out: expected %h, got %h", x.byte_val, b);
        mismatches++;
      end
      if (e !== x.range_err) begin
        $error("range_error: expected %b, got %b", x.range_err, e);
        mismatches++;
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [bfgs_pkg::CMD_W-1:0]   in_cmd;
  logic [bfgs_pkg::ADDR_W-1:0]  in_byte_addr;
  logic [bfgs_pkg::BYTE_W-1:0]  in_byte_in;
  logic [bfgs_pkg::OFF_W-1:0]   in_bit_offset;
  logic [bfgs_pkg::LEN_W-1:0]   in_bit_length;
  logic [bfgs_pkg::FIELD_W-1:0] in_field_in;
  logic                         out_valid;
  logic                         out_stall;
  logic [bfgs_pkg::FIELD_W-1:0] out_field_out;
  logic [bfgs_pkg::BYTE_W-1:0]  out_byte_out;
  logic                         out_range_error;

  logic               calm;          // high: neither side idles
  int unsigned        quiet_cycles;
  header_scoreboard   board;

  packet_bit_field_get_set dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_byte_addr    (in_byte_addr),
    .in_byte_in      (in_byte_in),
    .in_bit_offset   (in_bit_offset),
    .in_bit_length   (in_bit_length),
    .in_field_in     (in_field_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_field_out   (out_field_out),
    .out_byte_out    (out_byte_out),
    .out_range_error (out_range_error)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Result side: stall at random on the falling edge, hold off inside the
  // calm window so back-to-back results get through too.
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Sample both channels on the rising edge. Note accepted command words
  // first, then check accepted result words against the oldest owed one.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        board.note_word(in_cmd, in_byte_addr, in_byte_in, in_bit_offset,
                        in_bit_length, in_field_in);
      if (out_valid && !out_stall)
        board.check_word(out_field_out, out_byte_out, out_range_error);
    end
  end

  // Watchdog: count cycles where neither channel moves a word; a hung block
  // or a lost result ends the run here.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", quiet_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // Present one command word at the falling edge, idling first at random,
  // then hold it until the block takes it.
  task automatic send_word(bfgs_pkg::cmd_t c, int a, int b, int off, int len,
                           logic [bfgs_pkg::FIELD_W-1:0] fin);
    @(negedge clk);
    while (!calm && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= c;
    in_byte_addr  <= bfgs_pkg::ADDR_W'(a);
    in_byte_in    <= bfgs_pkg::BYTE_W'(b);
    in_bit_offset <= bfgs_pkg::OFF_W'(off);
    in_bit_length <= bfgs_pkg::LEN_W'(len);
    in_field_in   <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Random command word. Field offsets crowd the first 16 bytes so that
  // inserts and extracts overlap, and the buffer tail so that the end check
  // trips; lengths include zero, oversize and full 64-bit fields.
  task automatic send_random_word();
    bfgs_pkg::cmd_t c;
    int             off;
    int             len;
    int unsigned    roll;
    roll = $urandom_range(99);
    if (roll < 15)      c = bfgs_pkg::CMD_WR_BYTE;
    else if (roll < 30) c = bfgs_pkg::CMD_RD_BYTE;
    else if (roll < 65) c = bfgs_pkg::CMD_EXTRACT;
    else                c = bfgs_pkg::CMD_INSERT;
    roll = $urandom_range(99);
    if (roll < 45)      off = int'($urandom_range(127));
    else if (roll < 60) off = int'($urandom_range(bfgs_pkg::BUF_BITS - 1,
                                                  bfgs_pkg::BUF_BITS - 80));
    else                off = int'($urandom_range(bfgs_pkg::BUF_BITS - 1));
    roll = $urandom_range(99);
    if (roll < 6)       len = int'($urandom_range(127, bfgs_pkg::MAX_FIELD_BITS + 1));
    else if (roll < 8)  len = 0;
    else if (roll < 20) len = bfgs_pkg::MAX_FIELD_BITS;
    else                len = int'($urandom_range(bfgs_pkg::MAX_FIELD_BITS, 1));
    send_word(c, int'($urandom), int'($urandom), off, len, {$urandom, $urandom});
  endtask

  initial begin
    // drive every input to a known value before the first edge
    rst_n         = 1'b0;
    calm          = 1'b0;
    in_valid      = 1'b0;
    in_cmd        = bfgs_pkg::CMD_WR_BYTE;
    in_byte_addr  = '0;
    in_byte_in    = '0;
    in_bit_offset = '0;
    in_bit_length = '0;
    in_field_in   = '0;
    out_stall     = 1'b0;
    quiet_cycles  = 0;
    board         = new();

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening. Every byte read below was written first, since the
    // buffer holds garbage out of reset.
    send_word(bfgs_pkg::CMD_WR_BYTE, 0,   8'h00, 0, 0, '0);
    send_word(bfgs_pkg::CMD_WR_BYTE, 255, 8'hFF, 0, 0, '0);
    send_word(bfgs_pkg::CMD_WR_BYTE, 8,   8'h5A, 0, 0, '0);
    send_word(bfgs_pkg::CMD_WR_BYTE, 254, 8'h81, 0, 0, '0);
    send_word(bfgs_pkg::CMD_RD_BYTE, 0,   8'hFF, 0, 0, '0);
    send_word(bfgs_pkg::CMD_RD_BYTE, 255, 8'h00, 0, 0, '0);
    // full-width fields at both ends of the buffer, whole bytes only
    send_word(bfgs_pkg::CMD_INSERT, 0, 0, 0, bfgs_pkg::MAX_FIELD_BITS, '1);
    send_word(bfgs_pkg::CMD_INSERT, 0, 0,
              bfgs_pkg::BUF_BITS - bfgs_pkg::MAX_FIELD_BITS, bfgs_pkg::MAX_FIELD_BITS,
              64'h0123_4567_89AB_CDEF);
    send_word(bfgs_pkg::CMD_EXTRACT, 0, 0, 0, bfgs_pkg::MAX_FIELD_BITS, '0);
    // spans nine bytes
    send_word(bfgs_pkg::CMD_EXTRACT, 0, 0, 3, bfgs_pkg::MAX_FIELD_BITS, '0);
    send_word(bfgs_pkg::CMD_EXTRACT, 0, 0,
              bfgs_pkg::BUF_BITS - bfgs_pkg::MAX_FIELD_BITS, bfgs_pkg::MAX_FIELD_BITS, '0);
    // very last bit
    send_word(bfgs_pkg::CMD_EXTRACT, 0, 0, bfgs_pkg::BUF_BITS - 1, 1, '0);
    // extra value bits above the field length must be dropped
    send_word(bfgs_pkg::CMD_INSERT, 0, 0, bfgs_pkg::BUF_BITS - 1, 1,
              64'hFFFF_FFFF_FFFF_FFFE);
    send_word(bfgs_pkg::CMD_INSERT, 0, 0, 5, 13, 64'hDEAD_BEEF_0000_1234);
    send_word(bfgs_pkg::CMD_RD_BYTE, 0,   0, 0, 0, '0);
    send_word(bfgs_pkg::CMD_RD_BYTE, 1,   0, 0, 0, '0);
    send_word(bfgs_pkg::CMD_RD_BYTE, 255, 0, 0, 0, '0);
    // refusals: zero length, oversize length, field past the buffer end
    send_word(bfgs_pkg::CMD_EXTRACT, 0, 0, 0,  0,   '0);
    send_word(bfgs_pkg::CMD_INSERT,  0, 0, 10, 0,   '1);
    send_word(bfgs_pkg::CMD_EXTRACT, 0, 0, 0,  65,  '0);
    send_word(bfgs_pkg::CMD_INSERT,  0, 0, 0,  127, '1);
    send_word(bfgs_pkg::CMD_EXTRACT, 0, 0, bfgs_pkg::BUF_BITS - 1, 2, '0);
    send_word(bfgs_pkg::CMD_INSERT,  0, 0, 2000, bfgs_pkg::MAX_FIELD_BITS, '1);
    send_word(bfgs_pkg::CMD_EXTRACT, 0, 0,
              bfgs_pkg::BUF_BITS - bfgs_pkg::MAX_FIELD_BITS + 1,
              bfgs_pkg::MAX_FIELD_BITS, '0);
    // refused inserts must have left the tail alone
    send_word(bfgs_pkg::CMD_EXTRACT, 0, 0,
              bfgs_pkg::BUF_BITS - bfgs_pkg::MAX_FIELD_BITS, bfgs_pkg::MAX_FIELD_BITS, '0);

    // Fill every byte so random reads and extracts stay on written data.
    for (int k = 0; k < bfgs_pkg::BUF_BYTES; k++)
      send_word(bfgs_pkg::CMD_WR_BYTE, k, int'($urandom), int'($urandom),
                int'($urandom), {$urandom, $urandom});

    for (int k = 0; k < RANDOM_WORDS; k++) begin
      calm = (k >= CALM_FIRST) && (k < CALM_LAST);
      send_random_word();
    end
    calm = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;

    // drain: wait for every owed result, then give strays time to show up
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d byte writes, %0d byte reads, %0d extracts and %0d inserts;",
             board.cmd_seen[bfgs_pkg::CMD_WR_BYTE], board.cmd_seen[bfgs_pkg::CMD_RD_BYTE],
             board.cmd_seen[bfgs_pkg::CMD_EXTRACT], board.cmd_seen[bfgs_pkg::CMD_INSERT]);
    $display("%0d of them were refused as out of range, %0d mismatches seen.",
             board.refused, board.mismatches);
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
